// ===== src/tpq_pkg.sv =====
// ---------------------------------------------------------------------------
// tpq_pkg
// shared types and codes of the two-priority timed event queue
// ---------------------------------------------------------------------------
`default_nettype none

package tpq_pkg;

  localparam int TAG_BITS   = 37;
  localparam int MATCH_BITS = 36;
  localparam int COUNT_BITS = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_TICK   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOT_DUE = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_RM_RD,
    S_RM_CMP,
    S_TK_CHK,
    S_POP_RD,
    S_POP_CMP,
    S_RESCH,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        prio;
    logic [31:0] when;
    logic [31:0] period;
    logic        repeats;
    logic [3:0]  event_kind;
    logic [31:0] event_key;
  } tpq_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic        fired_prio;
    logic [3:0]  fired_kind;
    logic [31:0] fired_key;
    logic [31:0] fired_time;
    logic [6:0]  high_count;
    logic [6:0]  low_count;
  } tpq_out_t;

endpackage

`default_nettype wire

// ===== src/two_priority_timed_event_queue_top.sv =====
// ---------------------------------------------------------------------------
// two_priority_timed_event_queue_top
// two sorted timer event queues, high and low priority
//
// usage: drive in_cmd and pulse start while busy is low; the command is taken
// at that edge and busy stays high until the result beat. the result is on
// out_res, marked by out_valid for exactly one cycle, and cannot be stalled.
// each queue is one memory, walked by a single compare/move sequencer with
// one entry read and one entry written at a time.
// walk of each command through the queue memory:
//   insert : entries that sort after the new event move up one place, then
//            the event is written into the gap
//   remove : every entry is read and those that do not match are packed down
//   tick   : the due head fires (high queue first) and the rest of its queue
//            moves down one place; a recurring event is then inserted again
//   tick that fires nothing or on empty queues, unused opcode, full queue: no walk
// the next command is taken in the cycle of the result beat.
// reset clears both fill counts; entry memories need no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module two_priority_timed_event_queue_top
  import tpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int TIME_BITS   = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire tpq_in_t  in_cmd,
  output logic          out_valid,
  output tpq_out_t      out_res
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TB = TIME_BITS;
  localparam int EW = 2 * TB + TAG_BITS;

  state_t           state_r, state_nxt;
  tpq_in_t          cmd_r, cmd_nxt;
  logic             q_r, q_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    w_r, w_nxt;
  logic [EW-1:0]    ent_r, ent_nxt;
  logic [CW-1:0]    hfill_r, hfill_nxt;
  logic [CW-1:0]    lfill_r, lfill_nxt;
  tpq_out_t         res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [EW-1:0]    wr_data;
  logic [EW-1:0]    rd_h, rd_l, rdat;

  logic             acc;
  logic [CW-1:0]    sel_fill, afill, idx_dec;
  logic [TB-1:0]    when_t, ent_time;
  logic             hdue, ldue, later, match, full_sel;
  logic [TB:0]      sum;
  logic [TB-1:0]    nt_sat, nt;

  tpq_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW)) u_high (
    .clk(clk), .we(wr_en & q_r), .waddr(wr_addr), .wdata(wr_data),
    .re(rd_en), .raddr(rd_addr), .rdata(rd_h)
  );

  tpq_mem #(.DEPTH(QUEUE_DEPTH), .WIDTH(EW)) u_low (
    .clk(clk), .we(wr_en & ~q_r), .waddr(wr_addr), .wdata(wr_data),
    .re(rd_en), .raddr(rd_addr), .rdata(rd_l)
  );

  assign busy      = (state_r != S_IDLE);
  assign acc       = start & ~busy;
  assign sel_fill  = in_cmd.prio ? hfill_r : lfill_r;
  assign full_sel  = (sel_fill == CW'(QUEUE_DEPTH));
  assign afill     = q_r ? hfill_r : lfill_r;
  assign rdat      = q_r ? rd_h : rd_l;
  assign idx_dec   = idx_r - CW'(1);
  assign when_t    = TB'(cmd_r.when);
  assign ent_time  = ent_r[TB-1:0];
  assign hdue      = (hfill_r != '0) && (when_t >= rd_h[TB-1:0]);
  assign ldue      = (lfill_r != '0) && (when_t >= rd_l[TB-1:0]);
  assign later     = (rdat[TB-1:0] > ent_time);
  assign match     = (rdat[EW-2:2*TB] == {cmd_r.event_kind, cmd_r.event_key});
  assign sum       = {1'b0, ent_time} + {1'b0, ent_r[2*TB-1:TB]};
  assign nt_sat    = sum[TB] ? {TB{1'b1}} : sum[TB-1:0];
  assign nt        = (nt_sat < when_t) ? when_t : nt_sat;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          unique case (op_t'(in_cmd.opcode))
            OP_INSERT: state_nxt = full_sel ? S_FIN : S_INS_RD;
            OP_TICK:   state_nxt = (hfill_r == '0 && lfill_r == '0) ? S_FIN : S_TK_CHK;
            OP_REMOVE: state_nxt = S_RM_RD;
            default:   state_nxt = S_FIN;
          endcase
        end
      end
      S_INS_RD:  state_nxt = (idx_r == '0) ? S_FIN : S_INS_CMP;
      S_INS_CMP: state_nxt = later ? S_INS_RD : S_FIN;
      S_RM_RD:   state_nxt = (idx_r == afill) ? S_FIN : S_RM_CMP;
      S_RM_CMP:  state_nxt = S_RM_RD;
      S_TK_CHK:  state_nxt = (hdue || ldue) ? S_POP_RD : S_FIN;
      S_POP_RD: begin
        if (idx_r == afill) begin
          state_nxt = ent_r[EW-1] ? S_RESCH : S_FIN;
        end else begin
          state_nxt = S_POP_CMP;
        end
      end
      S_POP_CMP: state_nxt = S_POP_RD;
      S_RESCH:   state_nxt = S_INS_RD;
      S_FIN:     state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_nxt       = cmd_r;
    q_nxt         = q_r;
    idx_nxt       = idx_r;
    w_nxt         = w_r;
    ent_nxt       = ent_r;
    hfill_nxt     = hfill_r;
    lfill_nxt     = lfill_r;
    res_nxt       = res_r;
    out_valid_nxt = (state_r == S_FIN);
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = '0;
    wr_data       = ent_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd_nxt        = in_cmd;
          q_nxt          = in_cmd.prio;
          res_nxt        = '0;
          res_nxt.status = ST_DONE;
          ent_nxt        = {in_cmd.repeats, in_cmd.event_kind, in_cmd.event_key,
                            TB'(in_cmd.period), TB'(in_cmd.when)};
          idx_nxt        = sel_fill;
          w_nxt          = '0;
          unique case (op_t'(in_cmd.opcode))
            OP_INSERT: begin
              if (full_sel) res_nxt.status = ST_FULL;
            end
            OP_TICK: begin
              if (hfill_r == '0 && lfill_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end
              rd_en = 1'b1;
            end
            OP_REMOVE: idx_nxt = '0;
            default: ;
          endcase
        end
      end
      S_INS_RD: begin
        if (idx_r == '0) begin
          wr_en = 1'b1;
          if (q_r) hfill_nxt = hfill_r + CW'(1);
          else lfill_nxt = lfill_r + CW'(1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_dec[AW-1:0];
        end
      end
      S_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = idx_r[AW-1:0];
        if (later) begin
          wr_data = rdat;
          idx_nxt = idx_dec;
        end else begin
          if (q_r) hfill_nxt = hfill_r + CW'(1);
          else lfill_nxt = lfill_r + CW'(1);
        end
      end
      S_RM_RD: begin
        if (idx_r == afill) begin
          if (q_r) hfill_nxt = w_r;
          else lfill_nxt = w_r;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r[AW-1:0];
        end
      end
      S_RM_CMP: begin
        idx_nxt = idx_r + CW'(1);
        if (!match) begin
          wr_en   = 1'b1;
          wr_addr = w_r[AW-1:0];
          wr_data = rdat;
          w_nxt   = w_r + CW'(1);
        end
      end
      S_TK_CHK: begin
        idx_nxt = CW'(1);
        if (hdue || ldue) begin
          q_nxt              = hdue;
          ent_nxt            = hdue ? rd_h : rd_l;
          res_nxt.fired      = 1'b1;
          res_nxt.fired_prio = hdue;
          res_nxt.fired_kind = ent_nxt[EW-2:EW-5];
          res_nxt.fired_key  = ent_nxt[2*TB+31:2*TB];
          res_nxt.fired_time = 32'(ent_nxt[TB-1:0]);
        end else begin
          res_nxt.status = ST_NOT_DUE;
        end
      end
      S_POP_RD: begin
        if (idx_r == afill) begin
          if (q_r) hfill_nxt = hfill_r - CW'(1);
          else lfill_nxt = lfill_r - CW'(1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_r[AW-1:0];
        end
      end
      S_POP_CMP: begin
        wr_en   = 1'b1;
        wr_addr = idx_dec[AW-1:0];
        wr_data = rdat;
        idx_nxt = idx_r + CW'(1);
      end
      S_RESCH: begin
        ent_nxt[TB-1:0] = nt;
        idx_nxt         = afill;
      end
      S_FIN: begin
        res_nxt.high_count = COUNT_BITS'(hfill_r);
        res_nxt.low_count  = COUNT_BITS'(lfill_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hfill_r     <= '0;
      lfill_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hfill_r     <= hfill_nxt;
      lfill_r     <= lfill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    q_r   <= q_nxt;
    idx_r <= idx_nxt;
    w_r   <= w_nxt;
    ent_r <= ent_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (hfill_r <= CW'(QUEUE_DEPTH)) && (lfill_r <= CW'(QUEUE_DEPTH)))
    else $error("queue fill beyond depth");

  a_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(state_r == S_FIN)))
    else $error("result beat outside finish");

  a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.fired) |-> (out_res.status == ST_DONE))
    else $error("fired event with error status");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status == ST_FULL) |->
      (q_r ? (hfill_r == CW'(QUEUE_DEPTH)) : (lfill_r == CW'(QUEUE_DEPTH))))
    else $error("full status on a queue with room");

endmodule

`default_nettype wire

// ===== src/tpq_mem.sv =====
// ---------------------------------------------------------------------------
// tpq_mem
// one-write one-read entry memory with registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module tpq_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 101
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== tb/two_priority_timed_event_queue_checker.sv =====
// ---------------------------------------------------------------------------
// two_priority_timed_event_queue_checker
// scoreboard for the two-priority timed event queue
//
// watches accepted commands, keeps its own copy of both sorted queues,
// predicts the result of each command and compares every result beat
// field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module two_priority_timed_event_queue_checker
  import tpq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     busy,
  input  wire tpq_in_t  in_cmd,
  input  wire logic     out_valid,
  input  wire tpq_out_t out_res,
  output int            errors,
  output int            pending,
  output int            beats_checked,
  output int            events_fired,
  output int            inserts_dropped
);

  localparam int DEPTH = 64;

  logic [31:0]         ev_time   [2][DEPTH];
  logic [31:0]         ev_period [2][DEPTH];
  logic [TAG_BITS-1:0] ev_tag    [2][DEPTH];
  int                  fill      [2];
  tpq_out_t            expected_results[$];

  function automatic bit queue_put(input bit p, input logic [31:0] t,
                                   input logic [31:0] per, input logic [TAG_BITS-1:0] tag);
    int pos;
    pos = 0;
    if (fill[p] >= DEPTH) return 0;
    while (pos < fill[p] && ev_time[p][pos] <= t) pos++;
    for (int i = fill[p]; i > pos; i--) begin
      ev_time[p][i]   = ev_time[p][i-1];
      ev_period[p][i] = ev_period[p][i-1];
      ev_tag[p][i]    = ev_tag[p][i-1];
    end
    ev_time[p][pos]   = t;
    ev_period[p][pos] = per;
    ev_tag[p][pos]    = tag;
    fill[p]++;
    return 1;
  endfunction

  function automatic tpq_out_t queue_step(input tpq_in_t c);
    tpq_out_t            r;
    int                  src;
    int                  w;
    logic [31:0]         t, per;
    logic [TAG_BITS-1:0] tag;
    logic [32:0]         sum;
    logic [31:0]         nt;
    r = '0;
    case (op_t'(c.opcode))
      OP_INSERT: begin
        if (!queue_put(c.prio, c.when, c.period, {c.repeats, c.event_kind, c.event_key}))
          r.status = ST_FULL;
      end
      OP_TICK: begin
        if (fill[0] == 0 && fill[1] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          src = -1;
          if (fill[1] > 0 && c.when >= ev_time[1][0]) src = 1;
          else if (fill[0] > 0 && c.when >= ev_time[0][0]) src = 0;
          if (src < 0) begin
            r.status = ST_NOT_DUE;
          end else begin
            t   = ev_time[src][0];
            per = ev_period[src][0];
            tag = ev_tag[src][0];
            for (int i = 1; i < fill[src]; i++) begin
              ev_time[src][i-1]   = ev_time[src][i];
              ev_period[src][i-1] = ev_period[src][i];
              ev_tag[src][i-1]    = ev_tag[src][i];
            end
            fill[src]--;
            r.fired      = 1'b1;
            r.fired_prio = src[0];
            r.fired_kind = tag[35:32];
            r.fired_key  = tag[31:0];
            r.fired_time = t;
            if (tag[36]) begin
              sum = {1'b0, t} + {1'b0, per};
              nt  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
              if (nt < c.when) nt = c.when;
              void'(queue_put(src[0], nt, per, tag));
            end
          end
        end
      end
      OP_REMOVE: begin
        w = 0;
        for (int i = 0; i < fill[c.prio]; i++) begin
          if (ev_tag[c.prio][i][MATCH_BITS-1:0] != {c.event_kind, c.event_key}) begin
            ev_time[c.prio][w]   = ev_time[c.prio][i];
            ev_period[c.prio][w] = ev_period[c.prio][i];
            ev_tag[c.prio][w]    = ev_tag[c.prio][i];
            w++;
          end
        end
        fill[c.prio] = w;
      end
      default: ;
    endcase
    r.high_count = fill[1][6:0];
    r.low_count  = fill[0][6:0];
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    tpq_out_t e;
    if (!rst_n) begin
      fill[0] = 0;
      fill[1] = 0;
      expected_results.delete();
      errors = 0;
      beats_checked = 0;
      events_fired = 0;
      inserts_dropped = 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: unexpected result beat %h", $time, out_res);
        end else begin
          e = expected_results[0];
          expected_results.delete(0);
          beats_checked++;
          if (e.fired) events_fired++;
          if (e.status == ST_FULL) inserts_dropped++;
          if (out_res.status !== e.status || out_res.fired !== e.fired ||
              out_res.fired_prio !== e.fired_prio || out_res.fired_kind !== e.fired_kind ||
              out_res.fired_key !== e.fired_key || out_res.fired_time !== e.fired_time ||
              out_res.high_count !== e.high_count || out_res.low_count !== e.low_count) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch on result beat %0d", $time, beats_checked);
              $display("  expected st=%0d f=%0b p=%0b k=%h key=%h t=%h hc=%0d lc=%0d",
                       e.status, e.fired, e.fired_prio, e.fired_kind, e.fired_key,
                       e.fired_time, e.high_count, e.low_count);
              $display("  actual   st=%0d f=%0b p=%0b k=%h key=%h t=%h hc=%0d lc=%0d",
                       out_res.status, out_res.fired, out_res.fired_prio, out_res.fired_kind,
                       out_res.fired_key, out_res.fired_time, out_res.high_count,
                       out_res.low_count);
            end
          end
        end
      end
      if (start && !busy) expected_results.push_back(queue_step(in_cmd));
    end
  end

endmodule

`default_nettype wire

// ===== tb/two_priority_timed_event_queue_top_test.sv =====
// ---------------------------------------------------------------------------
// two_priority_timed_event_queue_top_test
// testbench for the two-priority timed event queue
//
// drives a short directed set of commands (empty, not due, due, priority
// order, recurring events with saturation, removes, unused opcode), then
// random insert/tick/remove traffic on an advancing clock, including floods
// that fill both queues. results are checked by a separate scoreboard.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module two_priority_timed_event_queue_top_test;
  import tpq_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  tpq_in_t  in_cmd;
  logic     out_valid;
  tpq_out_t out_res;
  int       errors, pending, beats_checked, events_fired, inserts_dropped;
  int       sent;
  int       burst_left;
  logic [31:0] now;
  logic [31:0] key_pool[8];

  two_priority_timed_event_queue_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .out_valid(out_valid), .out_res(out_res)
  );

  two_priority_timed_event_queue_checker checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_cmd(in_cmd),
    .out_valid(out_valid), .out_res(out_res), .errors(errors), .pending(pending),
    .beats_checked(beats_checked), .events_fired(events_fired),
    .inserts_dropped(inserts_dropped)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // called at a falling edge; returns at a falling edge
  task automatic issue(input tpq_in_t c);
    in_cmd = c;
    start  = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start = 1'b0;
      repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 40) : $urandom_range(0, 3))
        @(negedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(0, 6);
    end
  endtask

  function automatic tpq_in_t make_cmd(input op_t op, input bit p, input logic [31:0] w,
                                       input logic [31:0] per, input bit rep,
                                       input logic [3:0] kind, input logic [31:0] key);
    tpq_in_t c;
    c.opcode = op; c.prio = p; c.when = w; c.period = per;
    c.repeats = rep; c.event_kind = kind; c.event_key = key;
    return c;
  endfunction

  function automatic logic [31:0] pick_key();
    return $urandom_range(0, 4) == 0 ? $urandom : key_pool[$urandom_range(0, 7)];
  endfunction

  function automatic tpq_in_t random_cmd();
    tpq_in_t c;
    int sel;
    sel = $urandom_range(0, 99);
    c.prio       = 1'($urandom_range(0, 1));
    c.repeats    = 1'($urandom_range(0, 1));
    c.event_kind = 4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 1));
    c.event_key  = pick_key();
    c.period     = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 50);
    if (sel < 45) begin
      c.opcode = OP_INSERT;
      c.when   = $urandom_range(0, 19) == 0 ? $urandom : now + $urandom_range(0, 80);
    end else if (sel < 85) begin
      now += $urandom_range(0, 25);
      c.opcode = OP_TICK;
      c.when   = $urandom_range(0, 49) == 0 ? 32'hFFFF_FFFF : now;
    end else if (sel < 97) begin
      c.opcode = OP_REMOVE;
      c.when   = $urandom;
    end else begin
      c.opcode = OP_NONE;
      c.when   = $urandom;
    end
    return c;
  endfunction

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = '0;
    sent = 0;
    burst_left = 0;
    now = 32'd1000;
    key_pool = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
                 $urandom, $urandom, $urandom, $urandom};
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed
    issue(make_cmd(OP_TICK,   0, 32'd5, 0, 0, 0, 0));
    issue(make_cmd(OP_INSERT, 0, 32'd100, 32'd10, 1, 4'hF, 32'hFFFF_FFFF));
    issue(make_cmd(OP_INSERT, 1, 32'd200, 32'd0, 0, 4'h0, 32'h0));
    issue(make_cmd(OP_INSERT, 1, 32'd200, 32'd7, 1, 4'h5, 32'h1234_5678));
    issue(make_cmd(OP_TICK,   0, 32'd50, 0, 0, 0, 0));
    issue(make_cmd(OP_TICK,   0, 32'd100, 0, 0, 0, 0));
    issue(make_cmd(OP_TICK,   0, 32'd300, 0, 0, 0, 0));
    issue(make_cmd(OP_TICK,   0, 32'd300, 0, 0, 0, 0));
    issue(make_cmd(OP_INSERT, 0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1, 4'hA, 32'hAAAA_5555));
    issue(make_cmd(OP_TICK,   1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 4'hF, 32'hFFFF_FFFF));
    issue(make_cmd(OP_TICK,   0, 32'hFFFF_FFFF, 0, 0, 0, 0));
    issue(make_cmd(OP_NONE,   1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 4'hF, 32'hFFFF_FFFF));
    issue(make_cmd(OP_REMOVE, 0, 0, 0, 0, 4'hA, 32'h0000_5555));
    issue(make_cmd(OP_REMOVE, 0, 0, 0, 0, 4'hA, 32'hAAAA_5555));
    issue(make_cmd(OP_REMOVE, 1, 0, 0, 0, 4'h5, 32'h1234_5678));
    issue(make_cmd(OP_REMOVE, 0, 0, 0, 0, 4'hF, 32'hFFFF_FFFF));
    issue(make_cmd(OP_TICK,   0, 32'd0, 0, 0, 0, 0));

    // random traffic, with floods that fill both queues
    for (int n = 0; n < 500; n++) begin
      if (n == 150 || n == 350) begin
        for (int f = 0; f < 140; f++)
          issue(make_cmd(OP_INSERT, f >= 70, now + $urandom_range(0, 200),
                         $urandom_range(0, 30), 1'($urandom_range(0, 1)),
                         4'($urandom_range(0, 1)), pick_key()));
      end
      if (n % 200 == 199) begin
        start = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      issue(random_cmd());
    end

    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    $display("%0d commands sent, %0d results checked, %0d events fired, %0d inserts dropped",
             sent, beats_checked, events_fired, inserts_dropped);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/tpq_pkg.sv
src/tpq_mem.sv
src/two_priority_timed_event_queue_top.sv
tb/two_priority_timed_event_queue_checker.sv
tb/two_priority_timed_event_queue_top_test.sv
